// ===== hw/rtl/hpe_pkg.sv =====
// Helix point evaluator: shared constants, types and arithmetic helpers.
// Holds the CORDIC step, the arctangent table and the rounding/clamping functions.
// No dependencies.
package hpe_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int ANGLE_BITS    = 16;
  // quotient bits of the phase division that can be non-zero
  localparam int DIV_STEPS     = ANGLE_BITS + 14;
  localparam int CW            = 34;

  localparam logic signed [31:0] GAIN_INV_Q30 = 32'sd652032874;
  localparam logic [31:0]        TWO_PI_Q29   = 32'd3373259426;
  localparam logic signed [31:0] ONE_CM       = 32'sd65536;
  localparam logic signed [63:0] UNIT_ONE     = 64'sd1073741824;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SIGNED_RADIUS = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TAN_DIP       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_START_PHASE   = 3'd5;

  typedef logic [ANGLE_BITS-1:0] phase_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] a;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } sincos_t;

  // values that follow from the configuration alone
  typedef struct packed {
    logic signed [31:0] r;
    logic [63:0]        den;
    logic signed [31:0] cd;
    logic signed [31:0] sd;
    logic signed [31:0] k;
    logic signed [31:0] oz;
    sincos_t            ph0_sc;
    logic signed [33:0] xoff;
    logic signed [33:0] yoff;
    phase_t             ph0;
  } derived_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] phase_q32(input phase_t p);
    return 32'(p) << (32 - ANGLE_BITS);
  endfunction

  function automatic cordic_t cordic_init(input logic [31:0] z);
    cordic_t c;
    c.x = CW'(GAIN_INV_Q30);
    c.y = '0;
    c.a = CW'(z[29:0]);
    return c;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input logic [4:0] i);
    cordic_t n;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    dx = $signed(c.y) >>> i;
    dy = $signed(c.x) >>> i;
    at = CW'(atan_turn(i));
    if (!c.a[CW-1]) begin
      n.x = c.x - dx;
      n.y = c.y + dy;
      n.a = c.a - at;
    end else begin
      n.x = c.x + dx;
      n.y = c.y - dy;
      n.a = c.a + at;
    end
    return n;
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > UNIT_ONE) r = 32'sd1073741824;
    else if (v < -UNIT_ONE) r = -32'sd1073741824;
    else r = 32'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  // rounding (half up) shift of a Q1.30 product back to its scale
  function automatic logic signed [63:0] rshr30(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + 66'sd536870912;
    return 64'(t >>> 30);
  endfunction

  function automatic sincos_t cordic_finish(input cordic_t c, input logic [1:0] q);
    sincos_t r;
    logic signed [63:0] xv;
    logic signed [63:0] yv;
    logic signed [63:0] cv;
    logic signed [63:0] sv;
    xv = 64'($signed(c.x));
    yv = 64'($signed(c.y));
    case (q)
      2'd0: begin cv = xv;  sv = yv;  end
      2'd1: begin cv = -yv; sv = xv;  end
      2'd2: begin cv = -xv; sv = -yv; end
      default: begin cv = yv; sv = -xv; end
    endcase
    r.c = clamp_unit(cv);
    r.s = clamp_unit(sv);
    return r;
  endfunction

endpackage

// ===== hw/rtl/helix_point_evaluator_unit.sv =====
// Helix point evaluator top level: configuration unit, phase and CORDIC
// pipelines, output products and a two-entry result queue. Uses hpe_pkg.
//
//   channel   direction  payload                                   transfer when
//   s_*       in         flight_length (32)                        s_tvalid & s_tready
//   m_*       out        pos x/y/z, dir x/y/z, turn x/y (8 x 32)   m_tvalid & m_tready
//   cfg_*     in         register index, 32-bit data               cfg_we
//
// One flight length per cycle while s_tready is high, with one pipeline stage
// per quotient bit and per CORDIC iteration. After reset and after each
// register write the constants are re-derived by a shared sequencer, with
// s_tready low.
// Reset is synchronous; the pipeline halts only while both queue entries wait.
module helix_point_evaluator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // [31:0] flight_length
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [127:96] dir_x,
  // [159:128] dir_y, [191:160] dir_z, [223:192] turn_x, [255:224] turn_y
  output logic [255:0]                  m_tdata,
  input  logic                          cfg_we,
  input  logic [hpe_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  typedef struct packed {
    logic signed [31:0] turn_y;
    logic signed [31:0] turn_x;
    logic signed [31:0] dir_z;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } result_t;

  logic              busy;
  hpe_pkg::derived_t drv;
  logic              adv;
  logic              in_valid;

  logic               ph_valid;
  hpe_pkg::phase_t    ph_ang;
  logic signed [31:0] ph_pz;

  logic               cr_valid;
  hpe_pkg::sincos_t   cr_sc;
  logic signed [31:0] cr_pz;

  logic               t_valid;
  logic signed [65:0] px, py, dx, dy, tx, ty;
  logic signed [31:0] t_pz;

  result_t    res_new;
  result_t    q0, q1;
  logic [1:0] count;
  logic       push, pop;

  hpe_config_unit u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .drv       (drv)
  );

  assign adv      = count != 2'd2;
  assign s_tready = adv && !busy;
  assign in_valid = s_tvalid && s_tready;

  hpe_phase_pipe u_phase (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .flt       (s_tdata),
    .drv       (drv),
    .out_valid (ph_valid),
    .out_ang   (ph_ang),
    .out_pz    (ph_pz)
  );

  hpe_cordic_pipe u_cordic (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (ph_valid),
    .in_ang    (ph_ang),
    .in_side   (ph_pz),
    .out_valid (cr_valid),
    .out_sc    (cr_sc),
    .out_side  (cr_pz)
  );

  always_ff @(posedge clk) begin
    if (rst) t_valid <= 1'b0;
    else if (adv) t_valid <= cr_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px   <= 66'(drv.r) * (66'(cr_sc.s) - 66'(drv.ph0_sc.s));
      py   <= 66'(drv.r) * (66'(cr_sc.c) - 66'(drv.ph0_sc.c));
      dx   <= 66'(cr_sc.c) * 66'(drv.cd);
      dy   <= 66'(cr_sc.s) * 66'(drv.cd);
      tx   <= 66'(drv.k) * 66'(cr_sc.s);
      ty   <= 66'(drv.k) * 66'(cr_sc.c);
      t_pz <= cr_pz;
    end
  end

  always_comb begin
    res_new.pos_x  = hpe_pkg::sat32(hpe_pkg::rshr30(px) + 64'(drv.xoff));
    res_new.pos_y  = hpe_pkg::sat32(64'(drv.yoff) - hpe_pkg::rshr30(py));
    res_new.pos_z  = t_pz;
    res_new.dir_x  = hpe_pkg::clamp_unit(hpe_pkg::rshr30(dx));
    res_new.dir_y  = hpe_pkg::clamp_unit(hpe_pkg::rshr30(dy));
    res_new.dir_z  = drv.sd;
    res_new.turn_x = hpe_pkg::clamp_unit(-hpe_pkg::rshr30(tx));
    res_new.turn_y = hpe_pkg::clamp_unit(hpe_pkg::rshr30(ty));
  end

  assign push = t_valid && adv;
  assign pop  = m_tvalid && m_tready;

  // two-entry result queue; the head drives the master side
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) q0 <= res_new;
        else q1 <= res_new;
      end
      2'b01: q0 <= q1;
      2'b11: begin
        if (count == 2'd1) begin
          q0 <= res_new;
        end else begin
          q0 <= q1;
          q1 <= res_new;
        end
      end
      default: ;
    endcase
  end

  assign m_tvalid = count != 2'd0;
  assign m_tdata  = q0;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && count == 2'd2))
    else $error("result queue written while full");

  a_cfg_stalls_input: assert property (@(posedge clk) disable iff (rst) cfg_we |=> !s_tready)
    else $error("input taken while constants are re-derived");

  a_reset_stalls_input: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken straight after reset");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
      (count == 2'd2 && !m_tready) |=> count == 2'd2)
    else $error("full queue lost an entry without a transfer");

endmodule

// ===== hw/rtl/hpe_config_unit.sv =====
// Configuration registers and the sequencer that derives the helix constants.
// One shared multiplier, divider, square root and CORDIC step; uses hpe_pkg.
module hpe_config_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [hpe_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output logic                          busy,
  output hpe_pkg::derived_t             drv
);

  localparam logic [4:0] ST_SQ   = 5'd0;
  localparam logic [4:0] ST_RT0  = 5'd1;
  localparam logic [4:0] ST_RT   = 5'd2;
  localparam logic [4:0] ST_DV0  = 5'd3;
  localparam logic [4:0] ST_DVA  = 5'd4;
  localparam logic [4:0] ST_SDM  = 5'd5;
  localparam logic [4:0] ST_TCD  = 5'd6;
  localparam logic [4:0] ST_SD   = 5'd7;
  localparam logic [4:0] ST_K0   = 5'd8;
  localparam logic [4:0] ST_DVB  = 5'd9;
  localparam logic [4:0] ST_K    = 5'd10;
  localparam logic [4:0] ST_DEN  = 5'd11;
  localparam logic [4:0] ST_CRA  = 5'd12;
  localparam logic [4:0] ST_CR1  = 5'd13;
  localparam logic [4:0] ST_CRB  = 5'd14;
  localparam logic [4:0] ST_XM   = 5'd15;
  localparam logic [4:0] ST_XM2  = 5'd16;
  localparam logic [4:0] ST_YM   = 5'd17;
  localparam logic [4:0] ST_YO   = 5'd18;
  localparam logic [4:0] ST_DONE = 5'd19;

  logic signed [31:0] origin_x, origin_y, origin_z, signed_radius, tan_dip;
  logic [15:0]        start_phase;

  logic [4:0]  state;
  logic [5:0]  cnt;
  logic signed [65:0] prod;
  logic signed [32:0] mul_a, mul_b;

  logic [63:0] rv, res, bitm;
  logic [55:0] dvd, quo;
  logic [31:0] dsr, rem;
  hpe_pkg::cordic_t cor;
  hpe_pkg::sincos_t ph0_sc, ps_sc;
  logic signed [31:0] cd, sd, k;
  logic signed [33:0] xoff, yoff;
  logic [63:0] den;

  logic signed [31:0] r_cl;
  logic [31:0]        r_mag;
  logic [hpe_pkg::ANGLE_BITS+15:0] sp_wide;
  hpe_pkg::phase_t    sp_a, ph0;
  logic [31:0]        z_ph0, z_sp;

  logic [63:0] rt_sum;
  logic [32:0] remsh;
  logic        ge;
  logic signed [63:0] cd2;
  logic signed [65:0] rnd24;

  always_comb begin
    r_cl = signed_radius;
    if (!signed_radius[31] && signed_radius < hpe_pkg::ONE_CM) r_cl = hpe_pkg::ONE_CM;
    if (signed_radius[31] && signed_radius > -hpe_pkg::ONE_CM) r_cl = -hpe_pkg::ONE_CM;
    r_mag   = r_cl[31] ? (~r_cl + 32'd1) : r_cl;
    sp_wide = {start_phase, hpe_pkg::ANGLE_BITS'(0)};
    sp_a    = sp_wide[hpe_pkg::ANGLE_BITS+15:16];
    ph0     = sp_a + hpe_pkg::phase_t'(1 << (hpe_pkg::ANGLE_BITS - 2));
    z_ph0   = hpe_pkg::phase_q32(ph0);
    z_sp    = hpe_pkg::phase_q32(sp_a);
  end

  always_comb begin
    case (state)
      ST_SQ:   begin mul_a = 33'(tan_dip); mul_b = 33'(tan_dip); end
      ST_TCD:  begin mul_a = 33'(tan_dip); mul_b = 33'(cd); end
      ST_SD:   begin mul_a = 33'(cd);      mul_b = 33'(cd); end
      ST_K:    begin mul_a = {1'b0, r_mag}; mul_b = {1'b0, hpe_pkg::TWO_PI_Q29}; end
      ST_XM2:  begin mul_a = 33'(r_cl);    mul_b = 33'(ps_sc.c); end
      ST_YM:   begin mul_a = 33'(r_cl);    mul_b = 33'(ps_sc.s); end
      default: begin mul_a = '0;           mul_b = '0; end
    endcase
  end

  always_comb begin
    rt_sum = res + bitm;
    remsh  = {rem, dvd[55]};
    ge     = remsh >= {1'b0, dsr};
    cd2    = hpe_pkg::rshr30(prod);
    rnd24  = (prod + 66'sd8388608) >>> 24;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      origin_z      <= '0;
      signed_radius <= 32'sd6553600;
      tan_dip       <= '0;
      start_phase   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hpe_pkg::REG_ORIGIN_X:      origin_x      <= cfg_data;
        hpe_pkg::REG_ORIGIN_Y:      origin_y      <= cfg_data;
        hpe_pkg::REG_ORIGIN_Z:      origin_z      <= cfg_data;
        hpe_pkg::REG_SIGNED_RADIUS: signed_radius <= cfg_data;
        hpe_pkg::REG_TAN_DIP:       tan_dip       <= cfg_data;
        hpe_pkg::REG_START_PHASE:   start_phase   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // restart the derivation after reset and after every register write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= ST_SQ;
    end else begin
      case (state)
        ST_SQ:   state <= ST_RT0;
        ST_RT0:  state <= ST_RT;
        ST_RT:   if (bitm[0]) state <= ST_DV0;
        ST_DV0:  state <= ST_DVA;
        ST_DVA:  if (cnt == 6'd55) state <= ST_SDM;
        ST_SDM:  state <= ST_TCD;
        ST_TCD:  state <= ST_SD;
        ST_SD:   state <= ST_K0;
        ST_K0:   state <= ST_DVB;
        ST_DVB:  if (cnt == 6'd55) state <= ST_K;
        ST_K:    state <= ST_DEN;
        ST_DEN:  state <= ST_CRA;
        ST_CRA:  if (cnt == 6'(hpe_pkg::CORDIC_STAGES - 1)) state <= ST_CR1;
        ST_CR1:  state <= ST_CRB;
        ST_CRB:  if (cnt == 6'(hpe_pkg::CORDIC_STAGES - 1)) state <= ST_XM;
        ST_XM:   state <= ST_XM2;
        ST_XM2:  state <= ST_YM;
        ST_YM:   state <= ST_YO;
        ST_YO:   state <= ST_DONE;
        default: state <= ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_RT0: begin
        rv   <= (64'd1 << 48) + 64'(prod);
        res  <= '0;
        bitm <= 64'd1 << 62;
      end
      ST_RT: begin
        if (rv >= rt_sum) begin
          rv  <= rv - rt_sum;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
      end
      ST_DV0: begin
        dvd <= (56'd1 << 54) + 56'(res >> 1);
        dsr <= res[31:0];
        rem <= '0;
        cnt <= '0;
      end
      ST_DVA, ST_DVB: begin
        rem <= ge ? 32'(remsh - {1'b0, dsr}) : remsh[31:0];
        dvd <= dvd << 1;
        quo <= {quo[54:0], ge};
        cnt <= cnt + 6'd1;
      end
      ST_SDM: cd <= hpe_pkg::clamp_unit(64'(quo));
      ST_SD:  sd <= hpe_pkg::clamp_unit(64'(rnd24));
      ST_K0: begin
        dvd <= 56'(cd2) << 16;
        dsr <= r_mag;
        rem <= '0;
        cnt <= '0;
      end
      ST_K: k <= r_cl[31] ? -32'(quo) : 32'(quo);
      ST_DEN: begin
        den <= 64'(prod);
        cor <= hpe_pkg::cordic_init(z_ph0);
        cnt <= '0;
      end
      ST_CRA, ST_CRB: begin
        cor <= hpe_pkg::cordic_step(cor, cnt[4:0]);
        cnt <= cnt + 6'd1;
      end
      ST_CR1: begin
        ph0_sc <= hpe_pkg::cordic_finish(cor, z_ph0[31:30]);
        cor    <= hpe_pkg::cordic_init(z_sp);
        cnt    <= '0;
      end
      ST_XM:  ps_sc <= hpe_pkg::cordic_finish(cor, z_sp[31:30]);
      ST_YM:  xoff  <= 34'(cd2) + 34'(origin_x);
      ST_YO:  yoff  <= 34'(cd2) + 34'(origin_y);
      default: ;
    endcase
  end

  assign busy = state != ST_DONE;

  always_comb begin
    drv.r      = r_cl;
    drv.den    = den;
    drv.cd     = cd;
    drv.sd     = sd;
    drv.k      = k;
    drv.oz     = origin_z;
    drv.ph0_sc = ph0_sc;
    drv.xoff   = xoff;
    drv.yoff   = yoff;
    drv.ph0    = ph0;
  end

endmodule

// ===== hw/rtl/hpe_phase_pipe.sv =====
// Flight phase pipeline: flight length times cos dip, then a staged restoring
// division by the radius circumference, giving the turn phase. Uses hpe_pkg.
module hpe_phase_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [31:0] flt,
  input  hpe_pkg::derived_t  drv,
  output logic               out_valid,
  output hpe_pkg::phase_t    out_ang,
  output logic signed [31:0] out_pz
);

  localparam int DS = hpe_pkg::DIV_STEPS;
  localparam int AB = hpe_pkg::ANGLE_BITS;
  localparam int DW = 62 + AB;

  typedef struct packed {
    logic [63:0]        rem;
    logic [DS-1:0]      dlow;
    hpe_pkg::phase_t    q;
    logic               neg;
    logic signed [31:0] pz;
  } div_stage_t;

  logic               v1;
  logic signed [63:0] pn, pzp;
  logic               dv [DS+1];
  div_stage_t         ds [DS+1];

  logic [61:0]        num_mag;
  logic [DW-1:0]      dfull;
  logic signed [63:0] pz_r;

  always_comb begin
    num_mag = pn[63] ? 62'(-pn) : 62'(pn);
    dfull   = DW'(num_mag) << (AB - 1);
    pz_r    = hpe_pkg::rshr30(66'(pzp)) + 64'(drv.oz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      dv[0] <= 1'b0;
    end else if (adv) begin
      v1    <= in_valid;
      dv[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pn         <= flt * drv.cd;
      pzp        <= flt * drv.sd;
      ds[0].rem  <= 64'(dfull >> DS);
      ds[0].dlow <= dfull[DS-1:0];
      ds[0].q    <= '0;
      ds[0].neg  <= (pn < 0) != drv.r[31];
      ds[0].pz   <= hpe_pkg::sat32(pz_r);
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [63:0] remsh;
    logic        ge;
    assign remsh = {ds[j].rem[62:0], ds[j].dlow[DS-1]};
    assign ge    = remsh >= drv.den;

    always_ff @(posedge clk) begin
      if (rst) dv[j+1] <= 1'b0;
      else if (adv) dv[j+1] <= dv[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ds[j+1].rem  <= ge ? remsh - drv.den : remsh;
        ds[j+1].dlow <= ds[j].dlow << 1;
        ds[j+1].q    <= {ds[j].q[AB-2:0], ge};
        ds[j+1].neg  <= ds[j].neg;
        ds[j+1].pz   <= ds[j].pz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv[DS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ang <= drv.ph0 + (ds[DS].neg ? -ds[DS].q : ds[DS].q);
      out_pz  <= ds[DS].pz;
    end
  end

  // the division must never leave a remainder at or above the divisor
  property p_rem_below_den;
    @(posedge clk) disable iff (rst) dv[DS] |-> ds[DS].rem < drv.den;
  endproperty
  a_rem_below_den: assert property (p_rem_below_den)
    else $error("phase division remainder out of range");

endmodule

// ===== hw/rtl/hpe_cordic_pipe.sv =====
// Pipelined CORDIC rotation, one stage per iteration, with quadrant folding.
// Carries the z position alongside. Uses hpe_pkg.
module hpe_cordic_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  hpe_pkg::phase_t    in_ang,
  input  logic signed [31:0] in_side,
  output logic               out_valid,
  output hpe_pkg::sincos_t   out_sc,
  output logic signed [31:0] out_side
);

  localparam int CS = hpe_pkg::CORDIC_STAGES;

  logic               cv   [CS+1];
  hpe_pkg::cordic_t   st   [CS+1];
  logic [1:0]         quad [CS+1];
  logic signed [31:0] side [CS+1];
  logic [31:0]        z;

  assign z = hpe_pkg::phase_q32(in_ang);

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else if (adv) cv[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0]   <= hpe_pkg::cordic_init(z);
      quad[0] <= z[31:30];
      side[0] <= in_side;
    end
  end

  for (genvar j = 0; j < CS; j++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) cv[j+1] <= 1'b0;
      else if (adv) cv[j+1] <= cv[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[j+1]   <= hpe_pkg::cordic_step(st[j], 5'(j));
        quad[j+1] <= quad[j];
        side[j+1] <= side[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= cv[CS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sc   <= hpe_pkg::cordic_finish(st[CS], quad[CS]);
      out_side <= side[CS];
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for helix_point_evaluator_unit: drives flight lengths over
// several helix settings and compares every result with an in-bench predictor.
// Depends on hpe_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;

  typedef logic [7:0][31:0] point_t;

  localparam logic [hpe_pkg::REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [hpe_pkg::REG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint CM_Q16  = 64'sd65536;

  localparam logic [31:0] ARC_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000};

  localparam logic [31:0] EDGE_LENGTHS [9] = '{
    32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'hFFFFFFFF,
    32'h00010000, 32'hFFFF0000, 32'h00A00000, 32'h01234567};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [255:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [hpe_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor copy of the helix registers
  logic [31:0] hx_ox, hx_oy, hx_oz, hx_radius, hx_tan;
  logic [15:0] hx_phase;

  logic [31:0] pending_lengths[$];
  point_t      expected_points[$];
  int          errors = 0;
  bit          quiet = 1'b0;
  int          send_gap = 0;
  int          recv_gap = 0;

  helix_point_evaluator_unit u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip_unit(longint v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  function automatic longint clip_i32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void rotate(logic [31:0] z, output longint c, output longint s);
    longint x, y, a, dx, dy;
    x = 64'(hpe_pkg::GAIN_INV_Q30);
    y = 0;
    a = longint'(z[29:0]);
    for (int i = 0; i < hpe_pkg::CORDIC_STAGES && i < 32; i++) begin
      dx = fl_shr(y, i);
      dy = fl_shr(x, i);
      if (a >= 0) begin
        x -= dx; y += dy; a -= longint'(ARC_TURNS[i]);
      end else begin
        x += dx; y -= dy; a += longint'(ARC_TURNS[i]);
      end
    end
    case (z[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = clip_unit(c);
    s = clip_unit(s);
  endfunction

  function automatic logic [31:0] turn_q32(logic [63:0] ph);
    return 32'((ph << 32) >> hpe_pkg::ANGLE_BITS);
  endfunction

  function automatic point_t eval_helix(logic [31:0] len_bits);
    longint flt, r, t, cd, sd, num, cang, sang, cph0, sph0, cps, sps, cd2, k;
    logic [63:0] sq, mag, den, quo, rem, sp_a, quarter, ph0, ang, mask;
    point_t p;
    flt = longint'($signed(len_bits));
    r = longint'($signed(hx_radius));
    t = longint'($signed(hx_tan));
    mask = (64'd1 << hpe_pkg::ANGLE_BITS) - 1;
    // clamp small radii to one centimetre, keeping the sign
    if (r >= 0 && r < CM_Q16) r = CM_Q16;
    if (r < 0 && r > -CM_Q16) r = -CM_Q16;
    sq = int_sqrt((64'd1 << 48) + 64'(t * t));
    cd = clip_unit(longint'(((64'd1 << 54) + (sq >> 1)) / sq));
    sd = clip_unit(rnd_shr(t * cd, 24));
    num = flt * cd;
    mag = num < 0 ? 64'(-num) : 64'(num);
    den = 64'(r < 0 ? -r : r) * 64'(hpe_pkg::TWO_PI_Q29);
    quo = mag / den;
    rem = mag % den;
    quo = quo << (hpe_pkg::ANGLE_BITS - 1);
    for (int i = hpe_pkg::ANGLE_BITS - 1; i > 0; i--) begin
      rem = rem << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo + (64'd1 << (i - 1));
      end
    end
    if ((num < 0) != (r < 0)) quo = 64'd0 - quo;
    quo = quo & mask;
    sp_a = (64'(hx_phase) << hpe_pkg::ANGLE_BITS) >> 16;
    quarter = 64'd1 << (hpe_pkg::ANGLE_BITS - 2);
    ph0 = (sp_a + quarter) & mask;
    ang = (ph0 + quo) & mask;
    rotate(turn_q32(ang), cang, sang);
    rotate(turn_q32(ph0), cph0, sph0);
    rotate(turn_q32(sp_a), cps, sps);
    p[0] = 32'(clip_i32(rnd_shr(r * (sang - sph0), 30) + rnd_shr(r * cps, 30)
                        + longint'($signed(hx_ox))));
    p[1] = 32'(clip_i32(-rnd_shr(r * (cang - cph0), 30) + rnd_shr(r * sps, 30)
                        + longint'($signed(hx_oy))));
    p[2] = 32'(clip_i32(rnd_shr(flt * sd, 30) + longint'($signed(hx_oz))));
    p[3] = 32'(clip_unit(rnd_shr(cang * cd, 30)));
    p[4] = 32'(clip_unit(rnd_shr(sang * cd, 30)));
    p[5] = 32'(sd);
    cd2 = rnd_shr(cd * cd, 30);
    k = (cd2 * CM_Q16) / r;
    p[6] = 32'(clip_unit(-rnd_shr(k * sang, 30)));
    p[7] = 32'(clip_unit(rnd_shr(k * cang, 30)));
    return p;
  endfunction

  // sender: present queued flight lengths, predict on each transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_points.push_back(eval_helix(s_tdata));
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_lengths.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_lengths.pop_front();
          if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 9);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random back-pressure, check each transfer against the oldest expectation
  always @(posedge clk) begin
    point_t got, want;
    string names[8];
    names = '{"pos_x", "pos_y", "pos_z", "dir_x", "dir_y", "dir_z", "turn_x", "turn_y"};
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_points.size() == 0) begin
          $error("unexpected result transfer %h", m_tdata);
          errors++;
        end else begin
          want = expected_points.pop_front();
          for (int f = 0; f < 8; f++)
            if (got[f] !== want[f]) begin
              $error("%s: expected %h, got %h", names[f], want[f], got[f]);
              errors++;
            end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 8);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [hpe_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      hpe_pkg::REG_ORIGIN_X:      hx_ox = val;
      hpe_pkg::REG_ORIGIN_Y:      hx_oy = val;
      hpe_pkg::REG_ORIGIN_Z:      hx_oz = val;
      hpe_pkg::REG_SIGNED_RADIUS: hx_radius = val;
      hpe_pkg::REG_TAN_DIP:       hx_tan = val;
      hpe_pkg::REG_START_PHASE:   hx_phase = val[15:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_lengths.size() == 0 && !s_tvalid && expected_points.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_length();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
      2: return 32'($signed($urandom_range(0, 32'h0FFFFFFF)) - 32'sh08000000);
      default: return 32'($signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000);
    endcase
  endfunction

  function automatic logic [31:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h0001FFFF)) - 32'sh00010000);
      default: return 32'($signed($urandom_range(0, 32'h0FFFFFFF)) - 32'sh08000000);
    endcase
  endfunction

  function automatic logic [31:0] rand_tan();
    if ($urandom_range(0, 2) == 0) return $urandom();
    return 32'($signed($urandom_range(0, 32'h07FFFFFF)) - 32'sh04000000);
  endfunction

  initial begin
    hx_ox = '0; hx_oy = '0; hx_oz = '0;
    hx_radius = 32'd6553600; hx_tan = '0; hx_phase = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings, field extremes
    foreach (EDGE_LENGTHS[i])
      pending_lengths.push_back(EDGE_LENGTHS[i]);
    drain();

    // zero radius clamps, saturating origins, steepest dip, ignored spare indexes
    write_reg(hpe_pkg::REG_ORIGIN_X, 32'h7FFFFFFF);
    write_reg(hpe_pkg::REG_ORIGIN_Y, 32'h80000000);
    write_reg(hpe_pkg::REG_ORIGIN_Z, 32'h7FFFFFFF);
    write_reg(hpe_pkg::REG_SIGNED_RADIUS, 32'h0);
    write_reg(hpe_pkg::REG_TAN_DIP, 32'h7FFFFFFF);
    write_reg(hpe_pkg::REG_START_PHASE, 32'hABCDFFFF);
    write_reg(REG_SPARE_A, 32'h12345678);
    write_reg(REG_SPARE_B, 32'hFFFFFFFF);
    end_writes();
    pending_lengths.push_back(32'h7FFFFFFF);
    pending_lengths.push_back(32'h80000000);
    pending_lengths.push_back(32'h00008000);
    pending_lengths.push_back(32'h0);
    drain();

    // small negative radius, steepest negative dip
    write_reg(hpe_pkg::REG_ORIGIN_X, 32'h80000000);
    write_reg(hpe_pkg::REG_ORIGIN_Y, 32'h7FFFFFFF);
    write_reg(hpe_pkg::REG_ORIGIN_Z, 32'h80000000);
    write_reg(hpe_pkg::REG_SIGNED_RADIUS, 32'hFFFFFFFF);
    write_reg(hpe_pkg::REG_TAN_DIP, 32'h80000000);
    write_reg(hpe_pkg::REG_START_PHASE, 32'h0);
    end_writes();
    pending_lengths.push_back(32'h7FFFFFFF);
    pending_lengths.push_back(32'h80000000);
    pending_lengths.push_back(32'hFFFF8000);
    drain();

    // largest radii of both signs
    write_reg(hpe_pkg::REG_SIGNED_RADIUS, 32'h80000000);
    end_writes();
    pending_lengths.push_back(32'h7FFFFFFF);
    pending_lengths.push_back(32'h80000000);
    drain();
    write_reg(hpe_pkg::REG_SIGNED_RADIUS, 32'h7FFFFFFF);
    end_writes();
    pending_lengths.push_back(32'h7FFFFFFF);
    pending_lengths.push_back(32'h80000000);
    drain();

    // random helices, the last one without idling
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(hpe_pkg::REG_ORIGIN_X,
                ph == 0 ? $urandom() : 32'($signed($urandom_range(0, 32'hFFFFFF))));
      write_reg(hpe_pkg::REG_ORIGIN_Y,
                ph == 1 ? $urandom() : 32'($signed($urandom_range(0, 32'hFFFFFF))));
      write_reg(hpe_pkg::REG_ORIGIN_Z,
                ph == 2 ? $urandom() : 32'($signed($urandom_range(0, 32'hFFFFFF))));
      write_reg(hpe_pkg::REG_SIGNED_RADIUS, rand_radius());
      write_reg(hpe_pkg::REG_TAN_DIP, rand_tan());
      write_reg(hpe_pkg::REG_START_PHASE, $urandom());
      end_writes();
      if (ph == 7) quiet = 1'b1;
      repeat (48) pending_lengths.push_back(rand_length());
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
